@@ hw/rtl/rgbds_pkg.sv @@
// -----------------------------------------------------------------------------
// rgbds_pkg: shared definitions for the RGB565 nearest-neighbour gray scaler
// Field widths, register codes and reset values, gray weights and the tag
// that travels with a kept pixel through the conversion pipeline.
// -----------------------------------------------------------------------------
package rgbds_pkg;

   // Source frame size registers.
   localparam int unsigned SIZE_W = 12;
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd160;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd120;

   // Default output grid size (square grid).
   localparam int unsigned OUT_SIZE_DEFAULT = 64;

   // Register index codes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   // Output field widths.
   localparam int unsigned COORD_W = 6;
   localparam int unsigned GRAY_W  = 8;
   localparam int unsigned NORM_W  = 16;

   // Weighted sum 30R + 59G + 11B stays below 25600, so 15 bits suffice.
   localparam int unsigned SUM_W = 15;
   localparam logic [SUM_W-1:0] WEIGHT_RED   = 15'd30;
   localparam logic [SUM_W-1:0] WEIGHT_GREEN = 15'd59;
   localparam logic [SUM_W-1:0] WEIGHT_BLUE  = 15'd11;

   // Division by 100 as a multiplication by ceil(2^19 / 100) and a shift.
   // Exact for every sum below 43690, which covers the whole range.
   localparam int unsigned RECIP_W = 13;
   localparam logic [RECIP_W-1:0] DIV100_RECIP = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;
   localparam int unsigned PROD_W = SUM_W + RECIP_W;

   // Position information that goes with each kept pixel.
   typedef struct packed {
      logic [COORD_W-1:0] out_column;
      logic [COORD_W-1:0] out_row;
      logic               frame_last;
   } sample_tag_type;

endpackage

@@ hw/rtl/rgb565_nearest_downscale_gray.sv @@
// -----------------------------------------------------------------------------
// rgb565_nearest_downscale_gray: nearest-neighbour downscaler to gray
// Selects an OUT_SIZE x OUT_SIZE grid of pixels from an RGB565 camera frame
// and delivers each selected pixel as an 8-bit gray level and its fraction.
// -----------------------------------------------------------------------------
// Usage:
//   The request channel carries one source pixel per request, in raster
//   order, as two bytes (first byte low). Pixels off the output grid are
//   taken and dropped; each pixel on the grid gives one response with its
//   grid column and row, the gray level, gray*257 and a flag on the last
//   sample of the frame.
//   One request is taken every cycle while req_stall is low. A response
//   becomes valid once it has passed the three register stages of the
//   conversion (capture, weighted sum, divide by 100).
//   While the receiver stalls, the pending response holds; requests are
//   still taken until the pipeline stages behind it are full, then
//   req_stall rises.
//   The user writes the size registers through the csr port while the block
//   is idle; the block does not enforce this. Any write restarts the frame.
//   Sizes below the grid act as the grid. Reset sets the size to 160 x 120,
//   clears all counters and empties the pipeline.
// -----------------------------------------------------------------------------
module rgb565_nearest_downscale_gray #(
   parameter int unsigned OUT_SIZE = rgbds_pkg::OUT_SIZE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [rgbds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rgbds_pkg::SIZE_W-1:0]         csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_first_byte,
   input  logic [7:0]                           req_second_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rgbds_pkg::COORD_W-1:0]        rsp_out_column,
   output logic [rgbds_pkg::COORD_W-1:0]        rsp_out_row,
   output logic [rgbds_pkg::GRAY_W-1:0]         rsp_gray_level,
   output logic [rgbds_pkg::NORM_W-1:0]         rsp_normalized_gray,
   output logic                                 rsp_frame_last
);

   logic                       accept;
   logic                       keep;
   rgbds_pkg::sample_tag_type  tag;
   rgbds_pkg::sample_tag_type  rsp_tag;

   assign accept = req_valid && !req_stall;

   rgbds_position #(
      .OUT_SIZE (OUT_SIZE)
   ) u_position (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .keep      (keep),
      .tag       (tag)
   );

   rgbds_gray u_gray (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept && keep),
      .in_stall       (req_stall),
      .in_first_byte  (req_first_byte),
      .in_second_byte (req_second_byte),
      .in_tag         (tag),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tag        (rsp_tag),
      .rsp_gray       (rsp_gray_level),
      .rsp_norm       (rsp_normalized_gray)
   );

   assign rsp_out_column = rsp_tag.out_column;
   assign rsp_out_row    = rsp_tag.out_row;
   assign rsp_frame_last = rsp_tag.frame_last;

endmodule

@@ hw/rtl/rgbds_position.sv @@
// -----------------------------------------------------------------------------
// rgbds_position: frame position tracking and pixel selection
// Holds the size registers and the source and output counters, decides for
// each request whether its pixel lands on the output grid, and tags it.
// -----------------------------------------------------------------------------
module rgbds_position #(
   parameter int unsigned OUT_SIZE = rgbds_pkg::OUT_SIZE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [rgbds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rgbds_pkg::SIZE_W-1:0]         csr_data,
   input  logic                                 accept,
   output logic                                 keep,
   output rgbds_pkg::sample_tag_type            tag
);

   localparam int unsigned OUT_W = $clog2(OUT_SIZE + 1);
   localparam int unsigned ACC_W = rgbds_pkg::SIZE_W + OUT_W;
   localparam logic [OUT_W-1:0] GRID_SIZE = OUT_W'(OUT_SIZE);
   localparam logic [OUT_W-1:0] GRID_LAST = OUT_W'(OUT_SIZE - 1);
   localparam logic [ACC_W-1:0] GRID_STEP = ACC_W'(OUT_SIZE);
   localparam logic [rgbds_pkg::SIZE_W-1:0] GRID_MIN = rgbds_pkg::SIZE_W'(OUT_SIZE);

   logic [rgbds_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [rgbds_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [rgbds_pkg::SIZE_W-1:0] src_col_ff, src_col_in;
   logic [rgbds_pkg::SIZE_W-1:0] src_row_ff, src_row_in;
   // Source position times the grid size, so that selection is a compare.
   logic [ACC_W-1:0]             src_col_sc_ff, src_col_sc_in;
   logic [ACC_W-1:0]             src_row_sc_ff, src_row_sc_in;
   logic [OUT_W-1:0]             out_col_ff, out_col_in;
   logic [OUT_W-1:0]             out_row_ff, out_row_in;
   logic [ACC_W-1:0]             col_acc_ff, col_acc_in;
   logic [ACC_W-1:0]             row_acc_ff, row_acc_in;

   logic [rgbds_pkg::SIZE_W-1:0] width_eff;
   logic [rgbds_pkg::SIZE_W-1:0] height_eff;
   logic [ACC_W-1:0]             col_diff;
   logic [ACC_W-1:0]             row_diff;
   logic                         col_kept;
   logic                         row_kept;
   logic                         row_end;
   logic                         frame_end;

   // Sizes below the grid are treated as the grid size.
   assign width_eff  = (width_ff  < GRID_MIN) ? GRID_MIN : width_ff;
   assign height_eff = (height_ff < GRID_MIN) ? GRID_MIN : height_ff;

   // The wanted source column is col_acc / OUT_SIZE; it matches the current
   // column exactly when col_acc lies in [col*OUT_SIZE, col*OUT_SIZE + OUT_SIZE).
   assign col_diff = col_acc_ff - src_col_sc_ff;
   assign row_diff = row_acc_ff - src_row_sc_ff;
   assign col_kept = (out_col_ff < GRID_SIZE) && (col_acc_ff >= src_col_sc_ff)
                     && (col_diff < GRID_STEP);
   assign row_kept = (out_row_ff < GRID_SIZE) && (row_acc_ff >= src_row_sc_ff)
                     && (row_diff < GRID_STEP);
   assign keep     = col_kept && row_kept;

   assign row_end   = ({1'b0, src_col_ff} + 13'd1) >= {1'b0, width_eff};
   assign frame_end = ({1'b0, src_row_ff} + 13'd1) >= {1'b0, height_eff};

   assign tag.out_column = rgbds_pkg::COORD_W'(out_col_ff);
   assign tag.out_row    = rgbds_pkg::COORD_W'(out_row_ff);
   assign tag.frame_last = (out_col_ff == GRID_LAST) && (out_row_ff == GRID_LAST);

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      src_col_in    = src_col_ff;
      src_row_in    = src_row_ff;
      src_col_sc_in = src_col_sc_ff;
      src_row_sc_in = src_row_sc_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      col_acc_in    = col_acc_ff;
      row_acc_in    = row_acc_ff;

      if (csr_write) begin
         unique case (csr_index)
            rgbds_pkg::CSR_SOURCE_WIDTH:  width_in  = csr_data;
            rgbds_pkg::CSR_SOURCE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
         // Any register write starts a new frame.
         src_col_in    = '0;
         src_row_in    = '0;
         src_col_sc_in = '0;
         src_row_sc_in = '0;
         out_col_in    = '0;
         out_row_in    = '0;
         col_acc_in    = '0;
         row_acc_in    = '0;
      end else if (accept) begin
         if (keep) begin
            out_col_in = out_col_ff + OUT_W'(1);
            col_acc_in = col_acc_ff + ACC_W'(width_eff);
         end
         if (row_end) begin
            src_col_in    = '0;
            src_col_sc_in = '0;
            out_col_in    = '0;
            col_acc_in    = '0;
            if (frame_end) begin
               src_row_in    = '0;
               src_row_sc_in = '0;
               out_row_in    = '0;
               row_acc_in    = '0;
            end else begin
               src_row_in    = src_row_ff + rgbds_pkg::SIZE_W'(1);
               src_row_sc_in = src_row_sc_ff + GRID_STEP;
               if (row_kept) begin
                  out_row_in = out_row_ff + OUT_W'(1);
                  row_acc_in = row_acc_ff + ACC_W'(height_eff);
               end
            end
         end else begin
            src_col_in    = src_col_ff + rgbds_pkg::SIZE_W'(1);
            src_col_sc_in = src_col_sc_ff + GRID_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= rgbds_pkg::WIDTH_RESET;
         height_ff     <= rgbds_pkg::HEIGHT_RESET;
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         src_col_sc_ff <= '0;
         src_row_sc_ff <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         col_acc_ff    <= '0;
         row_acc_ff    <= '0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         src_col_ff    <= src_col_in;
         src_row_ff    <= src_row_in;
         src_col_sc_ff <= src_col_sc_in;
         src_row_sc_ff <= src_row_sc_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         col_acc_ff    <= col_acc_in;
         row_acc_ff    <= row_acc_in;
      end
   end

endmodule

@@ hw/rtl/rgbds_gray.sv @@
// -----------------------------------------------------------------------------
// rgbds_gray: RGB565 to gray conversion pipeline
// Three register stages: captured pixel, weighted channel sum, and the
// result register holding gray = sum / 100, from which the 0.16 fraction is formed.
// -----------------------------------------------------------------------------
module rgbds_gray (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic [7:0]                            in_first_byte,
   input  logic [7:0]                            in_second_byte,
   input  rgbds_pkg::sample_tag_type             in_tag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rgbds_pkg::sample_tag_type             rsp_tag,
   output logic [rgbds_pkg::GRAY_W-1:0]          rsp_gray,
   output logic [rgbds_pkg::NORM_W-1:0]          rsp_norm
);

   logic                             s1_valid_ff, s1_valid_in;
   logic [7:0]                       s1_first_ff;
   logic [7:0]                       s1_second_ff;
   rgbds_pkg::sample_tag_type        s1_tag_ff;

   logic                             s2_valid_ff, s2_valid_in;
   logic [rgbds_pkg::SUM_W-1:0]      s2_sum_ff, s2_sum_in;
   rgbds_pkg::sample_tag_type        s2_tag_ff;

   logic                             out_valid_ff, out_valid_in;
   logic [rgbds_pkg::GRAY_W-1:0]     out_gray_ff, out_gray_in;
   rgbds_pkg::sample_tag_type        out_tag_ff;

   logic                             out_ready;
   logic                             s2_ready;
   logic                             s1_ready;
   logic [rgbds_pkg::SUM_W-1:0]      red;
   logic [rgbds_pkg::SUM_W-1:0]      green;
   logic [rgbds_pkg::SUM_W-1:0]      blue;
   logic [rgbds_pkg::PROD_W-1:0]     product;

   // Each stage moves on when it is empty or the one after it moves on.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_stall  = !s1_ready;

   // Channels expanded to 8 bits with the low bits zero.
   assign red   = rgbds_pkg::SUM_W'({s1_second_ff[7:3], 3'b000});
   assign green = rgbds_pkg::SUM_W'({s1_second_ff[2:0], s1_first_ff[7:5], 2'b00});
   assign blue  = rgbds_pkg::SUM_W'({s1_first_ff[4:0], 3'b000});

   assign s2_sum_in = red * rgbds_pkg::WEIGHT_RED + green * rgbds_pkg::WEIGHT_GREEN
                      + blue * rgbds_pkg::WEIGHT_BLUE;

   assign product     = rgbds_pkg::PROD_W'(s2_sum_ff)
                        * rgbds_pkg::PROD_W'(rgbds_pkg::DIV100_RECIP);
   assign out_gray_in = product[rgbds_pkg::DIV100_SHIFT +: rgbds_pkg::GRAY_W];

   assign s1_valid_in  = s1_ready ? in_valid    : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_first_ff  <= in_first_byte;
         s1_second_ff <= in_second_byte;
         s1_tag_ff    <= in_tag;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_sum_ff <= s2_sum_in;
         s2_tag_ff <= s1_tag_ff;
      end
      if (out_ready && s2_valid_ff) begin
         out_gray_ff <= out_gray_in;
         out_tag_ff  <= s2_tag_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_tag   = out_tag_ff;
   assign rsp_gray  = out_gray_ff;
   // gray / 255 in 0.16 format is gray * 257, the byte repeated.
   assign rsp_norm  = {out_gray_ff, out_gray_ff};

endmodule
